### rtl/sprc_pkg.sv
// Shared types and constants for the stepper position ramp controller.
package sprc_pkg;

  // Field and register widths
  localparam int unsigned PosW    = 25;
  localparam int unsigned FreqW   = 14;
  localparam int unsigned PeriodW = 7;
  localparam int unsigned DbW     = 22;
  localparam int unsigned DeltaW  = FreqW + PeriodW;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CfgTickPeriod = 1'b0,
    CfgDeadband   = 1'b1
  } cfg_idx_e;

  // Configuration reset values
  localparam logic [PeriodW-1:0] TickPeriodReset = 7'd10;
  localparam logic [DbW-1:0]     DeadbandReset   = 22'd80000;

  // Target clamp (+/-10000000) and position saturation limits
  localparam logic signed [PosW-1:0] TargetMax = 25'sd10000000;
  localparam logic signed [PosW-1:0] TargetMin = -25'sd10000000;
  localparam logic signed [PosW:0]   PosMax    = 26'sd16000000;
  localparam logic signed [PosW:0]   PosMin    = -26'sd16000000;

  // Frequency ramp steps in Hz
  localparam logic [FreqW-1:0] FreqMax  = 14'd9600;
  localparam logic [FreqW-1:0] FreqMin  = 14'd800;
  localparam logic [FreqW-1:0] FreqFifth   = 14'(9600 / 5);
  localparam logic [FreqW-1:0] FreqQuarter = 14'(9600 / 4);
  localparam logic [FreqW-1:0] FreqHalf    = 14'(9600 / 2);

  // Next step of the ramp; frequencies off the ramp hold
  function automatic logic [FreqW-1:0] ramp_next(input logic [FreqW-1:0] f);
    logic [FreqW-1:0] r;
    case (f)
      14'd0:       r = FreqMin;
      FreqMin:     r = FreqFifth;
      FreqFifth:   r = FreqQuarter;
      FreqQuarter: r = FreqHalf;
      FreqHalf:    r = FreqMax;
      default:     r = f;
    endcase
    return r;
  endfunction

endpackage

### rtl/stepper_position_ramp_control.sv
// Top level: one stepper axis, position integration, deadband and frequency ramp.
// Path: input register at the accepting edge, then result register; one multiply, add and
// compare between them.
// Throughput: one transaction per cycle while the result channel is not stalled; the axis
// state updates as each item leaves the input register, so consecutive ticks chain with no gap.
// Reset: asynchronous, active low; clears position, frequency and direction to zero and
// loads tick period 10 ms and deadband 80000. Results are held until taken.
module stepper_position_ramp_control
  import sprc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_index_i,
  input  logic [DbW-1:0]         cfg_data_i,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [PosW-1:0] target_position_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [FreqW-1:0]       step_frequency_o,
  output logic                   move_direction_o,
  output logic signed [PosW-1:0] estimated_position_o
);

  // Configuration registers
  logic [PeriodW-1:0] period_q;
  logic [DbW-1:0]     db_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= TickPeriodReset;
      db_q     <= DeadbandReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgTickPeriod: period_q <= cfg_data_i[PeriodW-1:0];
        CfgDeadband:   db_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: input register feeds the result register
  logic                   s1_valid_q;
  logic signed [PosW-1:0] tgt_q;
  logic                   s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Capture target on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tgt_q <= target_position_i;
    end
  end

  // Axis state; the previous direction always equals the stored direction
  logic signed [PosW-1:0] pos_q, pos_d;
  logic [FreqW-1:0]       freq_q, freq_d;
  logic                   dir_q, dir_d;

  logic [DeltaW-1:0]      delta;
  logic signed [PosW:0]   pos_ext, pos_sum, pos_sat;
  logic signed [PosW-1:0] tgt_c;
  logic signed [PosW:0]   err, db_s, db_n;
  logic                   in_band, err_hi, err_lo;

  // Advance and saturate the position
  always_comb begin
    delta   = DeltaW'(freq_q) * DeltaW'(period_q);
    pos_ext = {pos_q[PosW-1], pos_q};
    if (dir_q) begin
      pos_sum = pos_ext - $signed({{(PosW+1-DeltaW){1'b0}}, delta});
    end else begin
      pos_sum = pos_ext + $signed({{(PosW+1-DeltaW){1'b0}}, delta});
    end
    if (pos_sum > PosMax) begin
      pos_sat = PosMax;
    end else if (pos_sum < PosMin) begin
      pos_sat = PosMin;
    end else begin
      pos_sat = pos_sum;
    end
    pos_d = pos_sat[PosW-1:0];
  end

  // Clamp target, form error, compare with deadband, ramp
  always_comb begin
    if (tgt_q > TargetMax) begin
      tgt_c = TargetMax;
    end else if (tgt_q < TargetMin) begin
      tgt_c = TargetMin;
    end else begin
      tgt_c = tgt_q;
    end
    err     = {tgt_c[PosW-1], tgt_c} - pos_sat;
    db_s    = $signed({{(PosW+1-DbW){1'b0}}, db_q});
    db_n    = -db_s;
    err_hi  = err > db_s;
    err_lo  = err < db_n;
    in_band = (err < db_s) && (err > db_n);
    dir_d   = dir_q;
    freq_d  = 14'd0;
    if (!in_band) begin
      if (err_hi) begin
        dir_d = 1'b0;
      end else if (err_lo) begin
        dir_d = 1'b1;
      end
      freq_d = ramp_next(freq_q);
      // drop to zero on reversal
      if (dir_d != dir_q) begin
        freq_d = 14'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      freq_q <= '0;
      dir_q  <= 1'b0;
    end else if (s1_adv) begin
      pos_q  <= pos_d;
      freq_q <= freq_d;
      dir_q  <= dir_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (!out_valid_o || out_ready_i) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      step_frequency_o     <= freq_d;
      move_direction_o     <= dir_d;
      estimated_position_o <= pos_d;
    end
  end

  // Assertions
  a_rev_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && dir_d != dir_q) |-> freq_d == 14'd0)
    else $error("reversal with nonzero frequency");

  a_freq_on_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (step_frequency_o == 14'd0 || step_frequency_o == FreqMin ||
      step_frequency_o == FreqFifth || step_frequency_o == FreqQuarter ||
      step_frequency_o == FreqHalf || step_frequency_o == FreqMax))
    else $error("frequency off the ramp");

  a_ramp_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && freq_d != 14'd0) |-> (freq_d > freq_q || freq_d == FreqMax))
    else $error("ramp did not advance");

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ($signed({estimated_position_o[PosW-1], estimated_position_o}) <= PosMax &&
       $signed({estimated_position_o[PosW-1], estimated_position_o}) >= PosMin))
    else $error("position beyond saturation limit");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(s1_adv) |-> ($stable(pos_q) && $stable(freq_q) && $stable(dir_q)))
    else $error("axis state changed without a tick");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the stepper position ramp controller.
module tb_top;
  import sprc_pkg::*;

  typedef struct {
    logic [FreqW-1:0]       freq;
    logic                   dir;
    logic signed [PosW-1:0] pos;
  } tick_result_t;

  // Clock, reset and block inputs, all known from time zero
  logic                   clk_i             = 1'b0;
  logic                   rst_ni            = 1'b0;
  logic                   cfg_we_i          = 1'b0;
  logic [0:0]             cfg_index_i       = '0;
  logic [DbW-1:0]         cfg_data_i        = '0;
  logic                   in_valid_i        = 1'b0;
  logic signed [PosW-1:0] target_position_i = '0;
  logic                   out_ready_i       = 1'b0;
  logic                   in_ready_o;
  logic                   out_valid_o;
  logic [FreqW-1:0]       step_frequency_o;
  logic                   move_direction_o;
  logic signed [PosW-1:0] estimated_position_o;

  // Pending targets and predicted tick results
  logic signed [PosW-1:0] target_q[$];
  tick_result_t           tick_result_q[$];

  // Shadow copy of the registers and the axis state
  logic [PeriodW-1:0] period_cfg   = TickPeriodReset;
  logic [DbW-1:0]     deadband_cfg = DeadbandReset;
  longint             axis_pos     = 0;
  logic [FreqW-1:0]   axis_freq    = '0;
  logic               axis_dir     = 1'b0;
  logic               axis_prev_dir = 1'b0;

  // Run bookkeeping
  int  err_count     = 0;
  int  ticks_sent    = 0;
  int  results_seen  = 0;
  int  edge_ticks    = 0;
  int  reversals     = 0;
  int  settings_used = 1;
  bit  idle_en       = 1'b1;
  int  gap_left      = 0;
  int  stall_left    = 0;
  int  hold_left     = 0;
  bit  hold_done     = 1'b0;
  int  quiet_cycles  = 0;
  tick_result_t got_exp;

  stepper_position_ramp_control dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .target_position_i   (target_position_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .step_frequency_o    (step_frequency_o),
    .move_direction_o    (move_direction_o),
    .estimated_position_o(estimated_position_o)
  );

  always #4 clk_i = ~clk_i;

  // Advance the shadow axis by one tick and queue its result
  function automatic void advance_axis(input logic signed [PosW-1:0] target_raw);
    longint       aim, step, gap, band;
    tick_result_t r;
    aim = longint'(target_raw);
    if (aim > TargetMax) aim = TargetMax;
    else if (aim < TargetMin) aim = TargetMin;
    step = longint'(axis_freq) * longint'(period_cfg);
    axis_pos = axis_dir ? axis_pos - step : axis_pos + step;
    if (axis_pos > PosMax) axis_pos = PosMax;
    else if (axis_pos < PosMin) axis_pos = PosMin;
    gap  = aim - axis_pos;
    band = longint'(deadband_cfg);
    if (gap < band && gap > -band) begin
      axis_freq = '0;
    end else begin
      if (gap == band || gap == -band) edge_ticks++;
      if (gap > band) axis_dir = 1'b0;
      else if (gap < -band) axis_dir = 1'b1;
      case (axis_freq)
        14'd0:       axis_freq = FreqMin;
        FreqMin:     axis_freq = FreqFifth;
        FreqFifth:   axis_freq = FreqQuarter;
        FreqQuarter: axis_freq = FreqHalf;
        FreqHalf:    axis_freq = FreqMax;
        default:     ;
      endcase
      if (axis_dir != axis_prev_dir) begin
        axis_freq = '0;
        reversals++;
      end
    end
    axis_prev_dir = axis_dir;
    r.freq = axis_freq;
    r.dir  = axis_dir;
    r.pos  = axis_pos[PosW-1:0];
    tick_result_q.push_back(r);
  endfunction

  function automatic int rand_span(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Driver: offer queued targets, with random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        advance_axis(target_position_i);
        ticks_sent++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (target_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 12);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i        <= 1'b1;
          target_position_i <= target_q.pop_front();
        end
      end
    end
  end

  // Monitor: compare each result transaction, drive result backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (tick_result_q.size() == 0) begin
          $error("unexpected result: step_frequency %0d move_direction %0d position %0d",
                 step_frequency_o, move_direction_o, estimated_position_o);
          err_count++;
        end else begin
          got_exp = tick_result_q.pop_front();
          if (step_frequency_o !== got_exp.freq) begin
            $error("step_frequency: expected %0d, got %0d", got_exp.freq, step_frequency_o);
            err_count++;
          end
          if (move_direction_o !== got_exp.dir) begin
            $error("move_direction: expected %0d, got %0d", got_exp.dir, move_direction_o);
            err_count++;
          end
          if (estimated_position_o !== got_exp.pos) begin
            $error("estimated_position: expected %0d, got %0d",
                   got_exp.pos, estimated_position_o);
            err_count++;
          end
        end
      end
      // Hold off once for a long stretch while targets keep coming
      if (!hold_done && results_seen >= 300 && target_q.size() > 20) begin
        hold_left = 160;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 5000) begin
        $display("FAIL stepper_position_ramp_control");
        $finish;
      end
    end
  end

  // Wait for every target to be taken and every result to arrive
  task automatic settle();
    while (target_q.size() != 0 || in_valid_i || tick_result_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DbW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgTickPeriod) period_cfg = val[PeriodW-1:0];
    else deadband_cfg = val;
  endtask

  // New register setting; the period write carries random upper bits
  task automatic set_axis(input logic [PeriodW-1:0] period, input logic [DbW-1:0] band);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(CfgTickPeriod, {junk[DbW-PeriodW-1:0], period});
    write_reg(CfgDeadband, band);
    settings_used++;
  endtask

  // Queue moves: mostly held targets so the ramp climbs, some noise
  task automatic queue_moves(input int count);
    int          n, reps, kind, aim;
    logic [31:0] raw;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        raw = $urandom;
        target_q.push_back(raw[PosW-1:0]);
        n++;
      end else if (kind == 1) begin
        reps = $urandom_range(1, 3);
        repeat (reps) target_q.push_back(PosW'(rand_span(10000000)));
        n += reps;
      end else begin
        aim  = $urandom_range(0, 1) ? rand_span(10000000) : rand_span(2000000);
        reps = $urandom_range(3, 25);
        repeat (reps) target_q.push_back(PosW'(aim));
        n += reps;
      end
    end
  endtask

  // Queue targets around the deadband edges of a frozen position
  task automatic queue_edges(input int count);
    longint aim, band;
    band = longint'(deadband_cfg);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) aim = axis_pos + rand_span(int'(band) + 2);
      else if ($urandom_range(0, 1) == 1) aim = axis_pos + band + rand_span(1);
      else aim = axis_pos - band + rand_span(1);
      target_q.push_back(aim[PosW-1:0]);
    end
  endtask

  initial begin
    longint frozen, band;
    // Directed: deadband inside and edge, full ramp, clamped extremes, reversals
    target_q.push_back(25'sd0);
    target_q.push_back(25'sd80000);
    repeat (6) target_q.push_back(25'h0FF_FFFF);
    repeat (3) target_q.push_back(25'h100_0000);
    target_q.push_back(TargetMin);
    repeat (2) target_q.push_back(TargetMax);
    target_q.push_back(25'sd0);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // Directed: freeze the position and hit both edges in both directions
    write_reg(CfgTickPeriod, {15'h7FFF, 7'd0});
    frozen = axis_pos;
    band   = longint'(deadband_cfg);
    target_q.push_back(PosW'(frozen + band));
    target_q.push_back(PosW'(frozen - band));
    target_q.push_back(PosW'(frozen - band - 1));
    target_q.push_back(PosW'(frozen - band));
    target_q.push_back(PosW'(frozen + band));
    target_q.push_back(PosW'(frozen + band - 1));
    repeat (3) target_q.push_back(PosW'(frozen + band + 1));
    settle();

    // Random phases across register extremes
    set_axis(7'd1, 22'd0);
    queue_moves(150);
    settle();
    set_axis(7'd127, 22'h3F_FFFF);
    queue_moves(150);
    settle();
    set_axis(7'd100, 22'd4000000);
    queue_moves(150);
    settle();
    set_axis(7'd0, DbW'($urandom_range(0, 200000)));
    queue_edges(120);
    settle();
    set_axis(PeriodW'($urandom_range(1, 100)), DbW'($urandom_range(0, 400000)));
    queue_moves(150);
    settle();
    // Last part runs with no idling on either side
    idle_en = 1'b0;
    set_axis(TickPeriodReset, DeadbandReset);
    queue_moves(150);
    settle();
    repeat (8) @(posedge clk_i);

    $display("Checked %0d ticks over %0d register settings: %0d on a deadband edge, %0d reversals.",
             results_seen, settings_used, edge_ticks, reversals);
    if (err_count == 0) begin
      $display("PASS stepper_position_ramp_control");
    end else begin
      $display("FAIL stepper_position_ramp_control");
    end
    $finish;
  end

endmodule
